FILE: hdl/sle_pkg.sv
// Shared types and constants for the sequential list engine.
package sle_pkg;

    localparam int CAPACITY = 64;
    localparam int POS_W    = 7;
    localparam int IDX_W    = 6;
    localparam int DATA_W   = 32;

    typedef enum logic [2:0] {
        REQ_INSERT = 3'd0,
        REQ_DELETE = 3'd1,
        REQ_GET    = 3'd2,
        REQ_LOCATE = 3'd3,
        REQ_PRIOR  = 3'd4,
        REQ_NEXT   = 3'd5,
        REQ_CLEAR  = 3'd6
    } sle_op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_RANGE   = 2'd1,
        ST_FULL    = 2'd2,
        ST_MISSING = 2'd3
    } sle_status_t;

    typedef struct packed {
        logic [2:0]              req_type;
        logic [POS_W-1:0]        position;
        logic signed [DATA_W-1:0] value;
    } sle_req_t;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [DATA_W-1:0] read_value;
        logic [IDX_W-1:0]        found_index;
        logic [POS_W-1:0]        length;
        logic                    is_empty;
    } sle_rsp_t;

    // Broadcast control to every cell of the chain.
    typedef struct packed {
        logic              ins;
        logic              del;
        logic [POS_W-1:0]  pos;
        logic [POS_W-1:0]  rd_pos;
        logic [POS_W-1:0]  count;
        logic [DATA_W-1:0] val;
    } sle_ctl_t;

endpackage

FILE: hdl/sle_cell.sv
// One list entry cell: holds a word, shifts with its neighbors, compares and reads out.
module sle_cell #(
    parameter int INDEX = 0
) (
    input  logic                      clk,
    input  sle_pkg::sle_ctl_t         ctl,
    input  logic [sle_pkg::DATA_W-1:0] left_data,
    input  logic [sle_pkg::DATA_W-1:0] right_data,
    output logic [sle_pkg::DATA_W-1:0] data,
    output logic                      match,
    output logic [sle_pkg::DATA_W-1:0] rd_part
);
    import sle_pkg::*;

    localparam logic [POS_W-1:0] MY_IDX = POS_W'(INDEX);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctl.ins)
        begin
            if (MY_IDX > ctl.pos)
            begin
                data_next = left_data;
            end
            else if (MY_IDX == ctl.pos)
            begin
                data_next = ctl.val;
            end
        end
        else if (ctl.del && (MY_IDX >= ctl.pos))
        begin
            data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign match   = (MY_IDX < ctl.count) && (data_reg == ctl.val);
    assign rd_part = (MY_IDX == ctl.rd_pos) ? data_reg : '0;

endmodule

FILE: hdl/sle_first.sv
// Find-first encoder over the cell match flags.
module sle_first (
    input  logic [sle_pkg::CAPACITY-1:0] flags,
    output logic                         hit,
    output logic [sle_pkg::IDX_W-1:0]    index
);
    import sle_pkg::*;

    logic [CAPACITY-1:0] first;
    logic [CAPACITY-1:0] sel [IDX_W];

    // isolate lowest set flag
    assign first = flags & (~flags + CAPACITY'(1));
    assign hit   = |flags;

    always_comb
    begin
        logic [IDX_W-1:0] k_idx;
        for (int b = 0; b < IDX_W; b++)
        begin
            for (int k = 0; k < CAPACITY; k++)
            begin
                k_idx     = IDX_W'(k);
                sel[b][k] = first[k] & k_idx[b];
            end
        end
        for (int b = 0; b < IDX_W; b++)
        begin
            index[b] = |sel[b];
        end
    end

endmodule

FILE: hdl/sequential_list_engine.sv
// Top level of the sequential list engine: request decode, cell chain and result register.
//
// The block keeps a list of up to 64 signed 32-bit words in a chain of 64 cells.
// A request is taken at any clock edge with start high (busy stays low, since the
// whole chain shifts, compares and reads in parallel). Its result appears on result
// with done high in the cycle after the request edge, so one request can be issued
// every cycle; the result must be captured in that cycle. Clear resets only the
// length; entries at or above the length are never read.
module sequential_list_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  sle_pkg::sle_req_t req,
    output logic              done,
    output sle_pkg::sle_rsp_t result
);
    import sle_pkg::*;

    logic                accept;
    logic [POS_W-1:0]    count_reg;
    logic [POS_W-1:0]    count_next;
    logic                done_reg;
    sle_rsp_t            result_reg;
    sle_rsp_t            result_next;
    sle_ctl_t            ctl;
    logic                ins_ok;
    logic                del_ok;
    logic                rd_en;
    logic                loc_ok;
    logic [1:0]          status;
    logic [POS_W-1:0]    rd_pos;
    logic [POS_W:0]      pos_p1;
    logic [DATA_W-1:0]   cell_data [CAPACITY];
    logic [DATA_W-1:0]   rd_parts  [CAPACITY];
    logic [CAPACITY-1:0] match;
    logic [CAPACITY-1:0] rd_col    [DATA_W];
    logic [DATA_W-1:0]   rd_word;
    logic                hit;
    logic [IDX_W-1:0]    found;

    assign busy   = 1'b0;
    assign accept = start & ~busy;
    assign pos_p1 = {1'b0, req.position} + (POS_W+1)'(1);

    always_comb
    begin
        status     = ST_OK;
        count_next = count_reg;
        ins_ok     = 1'b0;
        del_ok     = 1'b0;
        rd_en      = 1'b0;
        loc_ok     = 1'b0;
        rd_pos     = req.position;
        unique case (req.req_type)
            REQ_INSERT:
            begin
                if (req.position > count_reg)
                begin
                    status = ST_RANGE;
                end
                else if (count_reg == POS_W'(CAPACITY))
                begin
                    status = ST_FULL;
                end
                else
                begin
                    ins_ok     = 1'b1;
                    count_next = count_reg + POS_W'(1);
                end
            end
            REQ_DELETE:
            begin
                if (req.position >= count_reg)
                begin
                    status = ST_RANGE;
                end
                else
                begin
                    del_ok     = 1'b1;
                    count_next = count_reg - POS_W'(1);
                end
            end
            REQ_GET:
            begin
                if (req.position >= count_reg)
                begin
                    status = ST_RANGE;
                end
                else
                begin
                    rd_en = 1'b1;
                end
            end
            REQ_LOCATE:
            begin
                if (hit)
                begin
                    loc_ok = 1'b1;
                end
                else
                begin
                    status = ST_MISSING;
                end
            end
            REQ_PRIOR:
            begin
                if ((req.position == '0) || (req.position >= count_reg))
                begin
                    status = ST_RANGE;
                end
                else
                begin
                    rd_en  = 1'b1;
                    rd_pos = req.position - POS_W'(1);
                end
            end
            REQ_NEXT:
            begin
                if (pos_p1 >= {1'b0, count_reg})
                begin
                    status = ST_RANGE;
                end
                else
                begin
                    rd_en  = 1'b1;
                    rd_pos = pos_p1[POS_W-1:0];
                end
            end
            REQ_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        ctl.ins    = accept & ins_ok;
        ctl.del    = accept & del_ok;
        ctl.pos    = req.position;
        ctl.rd_pos = rd_pos;
        ctl.count  = count_reg;
        ctl.val    = req.value;
    end

    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        logic [DATA_W-1:0] left_data;
        logic [DATA_W-1:0] right_data;
        if (k == 0)
        begin : g_head
            assign left_data = '0;
        end
        else
        begin : g_body
            assign left_data = cell_data[k-1];
        end
        if (k == CAPACITY-1)
        begin : g_tail
            assign right_data = '0;
        end
        else
        begin : g_inner
            assign right_data = cell_data[k+1];
        end
        sle_cell #(
            .INDEX(k)
        ) u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .left_data (left_data),
            .right_data(right_data),
            .data      (cell_data[k]),
            .match     (match[k]),
            .rd_part   (rd_parts[k])
        );
    end

    always_comb
    begin
        for (int j = 0; j < DATA_W; j++)
        begin
            for (int k = 0; k < CAPACITY; k++)
            begin
                rd_col[j][k] = rd_parts[k][j];
            end
        end
        for (int j = 0; j < DATA_W; j++)
        begin
            rd_word[j] = |rd_col[j];
        end
    end

    sle_first u_first (
        .flags(match),
        .hit  (hit),
        .index(found)
    );

    always_comb
    begin
        result_next.status      = status;
        result_next.read_value  = rd_en ? rd_word : '0;
        result_next.found_index = loc_ok ? found : '0;
        result_next.length      = count_next;
        result_next.is_empty    = (count_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= POS_W'(CAPACITY))
        else $error("list length above capacity");

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done_reg)
        else $error("accepted request gave no result");

    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(accept))
        else $error("result without request");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.ins |=> (count_reg == $past(count_reg) + POS_W'(1)))
        else $error("insert did not grow list");

    a_len_matches: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (result_reg.length == count_reg))
        else $error("reported length differs from list length");

endmodule
